@@ sv/stc_pkg.sv @@
// stc_pkg: shared types and constants of the stepped ramp trip capture block
// no dependencies
`default_nettype none
package stc_pkg;

   localparam int VALUE_W = 32;
   localparam int TIME_W  = 40;
   localparam int DIVD_W  = 48;
   localparam int DIVS_W  = 32;
   localparam int FRAC_W  = 16;

   // operation codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_STOP  = 2'd2;

   // status codes
   localparam logic [2:0] ST_CODE_IDLE    = 3'd0;
   localparam logic [2:0] ST_CODE_RUNNING = 3'd1;
   localparam logic [2:0] ST_CODE_DONE    = 3'd2;
   localparam logic [2:0] ST_CODE_STOPPED = 3'd3;
   localparam logic [2:0] ST_CODE_BUSY    = 3'd4;
   localparam logic [2:0] ST_CODE_ZERO    = 3'd5;
   localparam logic [2:0] ST_CODE_WRONG   = 3'd6;
   localparam logic [2:0] ST_CODE_NOSTEP  = 3'd7;

   // register indexes
   localparam logic [2:0] REG_START    = 3'd0;
   localparam logic [2:0] REG_END      = 3'd1;
   localparam logic [2:0] REG_STEP     = 3'd2;
   localparam logic [2:0] REG_TICKS    = 3'd3;
   localparam logic [2:0] REG_MONITOR  = 3'd4;
   localparam logic [2:0] REG_QUANTITY = 3'd5;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PROG_WAIT,
      S_EXEC,
      S_START_WAIT,
      S_RATIO_WAIT,
      S_OUT
   } seq_state_type;

endpackage
`default_nettype wire

@@ sv/stc_divider.sv @@
// stc_divider: serial restoring unsigned divider, one quotient bit per cycle
// depends on stc_pkg
`default_nettype none
module stc_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [stc_pkg::DIVD_W-1:0]   dividend,
   input  wire logic [stc_pkg::DIVS_W-1:0]   divisor,
   output logic                              done,
   output logic [stc_pkg::DIVD_W-1:0]        quotient,
   output logic [stc_pkg::DIVS_W-1:0]        remainder
);
   import stc_pkg::*;

   logic [DIVD_W-1:0] quo_ff;
   logic [DIVS_W-1:0] rem_ff;
   logic [DIVS_W-1:0] dsr_ff;
   logic [5:0]        count_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIVS_W:0]   trial;
   logic [DIVS_W:0]   diff;

   // trial subtraction of the shifted partial remainder
   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= 6'(DIVD_W);
            quo_ff   <= dividend;
            rem_ff   <= '0;
            dsr_ff   <= divisor;
         end else if (busy_ff) begin
            if (!diff[DIVS_W]) begin
               rem_ff <= diff[DIVS_W-1:0];
               quo_ff <= {quo_ff[DIVD_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[DIVS_W-1:0];
               quo_ff <= {quo_ff[DIVD_W-2:0], 1'b0};
            end
            count_ff <= count_ff - 6'd1;
            if (count_ff == 6'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

@@ sv/stepped_ramp_trip_capture.sv @@
// stepped_ramp_trip_capture: ramp sequencer, trip capture and result register
// depends on stc_pkg and stc_divider
// sequence: accept, a progress divide once a run has set a step count, exec, a second divide on
// a valid start or a ratio-forming item, then output; the shared 48-bit serial divider does each divide
// items are taken one at a time, each only after the previous one has reached the output register;
// the next item is taken while the result waits
// reset: synchronous active high; config, run and state registers reset, no clearing pass
`default_nettype none
module stepped_ramp_trip_capture (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // bit 0: trip input
   input  wire logic [1:0]   req_tuser,   // operation
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // drive_value, quantity_out, progress_percent, trip_sampled, step_done, status,
   // pickup_value, dropoff_value, pickup_ticks, dropoff_ticks, reset_ratio, total_ticks
   output logic [263:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata
);
   import stc_pkg::*;

   // configuration registers
   logic signed [VALUE_W-1:0] cfg_start_ff, cfg_end_ff, cfg_step_ff;
   logic [31:0]               cfg_ticks_ff;
   logic                      cfg_monitor_ff;
   logic [3:0]                cfg_quantity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_start_ff    <= '0;
         cfg_end_ff      <= '0;
         cfg_step_ff     <= '0;
         cfg_ticks_ff    <= 32'd1000;
         cfg_monitor_ff  <= 1'b1;
         cfg_quantity_ff <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_START:    cfg_start_ff    <= csr_wdata;
            REG_END:      cfg_end_ff      <= csr_wdata;
            REG_STEP:     cfg_step_ff     <= csr_wdata;
            REG_TICKS:    cfg_ticks_ff    <= csr_wdata;
            REG_MONITOR:  cfg_monitor_ff  <= csr_wdata[0];
            REG_QUANTITY: cfg_quantity_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // run state
   logic                      run_active_ff, trip_prev_ff, ramp_up_ff;
   logic                      pickup_seen_ff, dropoff_seen_ff;
   logic signed [VALUE_W-1:0] level_ff, pickup_level_ff, dropoff_level_ff, ratio_ff;
   logic signed [VALUE_W-1:0] run_end_ff, run_step_ff;
   logic [31:0]               run_ticks_ff, step_index_ff, step_total_ff, hold_ff;
   logic                      run_monitor_ff;
   logic [TIME_W-1:0]         elapsed_ff, pickup_at_ff, dropoff_at_ff;
   logic [2:0]                last_status_ff;

   // per-item registers
   logic [1:0]                op_ff;
   logic                      trip_ff;
   logic signed [VALUE_W-1:0] shown_ff;
   logic [6:0]                prog_ff;
   logic                      sampled_ff, done_ff;
   logic [2:0]                status_ff;
   logic                      ratio_neg_ff;

   logic          rsp_valid_ff;
   logic [263:0]  rsp_data_ff;

   seq_state_type state_ff, state_in;

   // divider
   logic               div_start;
   logic [DIVD_W-1:0]  div_dividend;
   logic [DIVS_W-1:0]  div_divisor;
   logic               div_done;
   logic [DIVD_W-1:0]  div_quot;
   logic [DIVS_W-1:0]  div_rem;

   stc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // start checks from the registers
   logic signed [VALUE_W:0] range_s;
   logic [DIVS_W-1:0]       range_mag, step_mag;
   logic                    dir_up, bad_dir;
   assign range_s   = {cfg_end_ff[VALUE_W-1], cfg_end_ff} -
                      {cfg_start_ff[VALUE_W-1], cfg_start_ff};
   assign range_mag = range_s[VALUE_W] ? DIVS_W'(-range_s) : DIVS_W'(range_s);
   assign step_mag  = cfg_step_ff[VALUE_W-1] ? DIVS_W'(-cfg_step_ff) : DIVS_W'(cfg_step_ff);
   assign dir_up    = cfg_end_ff > cfg_start_ff;
   assign bad_dir   = (dir_up && cfg_step_ff[VALUE_W-1]) ||
                      (!dir_up && !cfg_step_ff[VALUE_W-1] && (cfg_step_ff != '0));

   // tick arithmetic
   logic [32:0]             hold_next;
   logic                    hold_end;
   logic signed [VALUE_W:0] next_sum;
   logic signed [VALUE_W-1:0] next_level;
   logic [TIME_W-1:0]       elapsed_next;
   logic                    rise, fall, ratio_ok;
   logic [38:0]             prog_num;
   assign hold_next    = {1'b0, hold_ff} + 33'd1;
   assign hold_end     = hold_next >= {1'b0, run_ticks_ff};
   assign next_sum     = {level_ff[VALUE_W-1], level_ff} +
                         {run_step_ff[VALUE_W-1], run_step_ff};
   assign elapsed_next = (elapsed_ff != '1) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign rise         = run_monitor_ff && !trip_prev_ff && trip_ff && !pickup_seen_ff;
   assign fall         = run_monitor_ff && trip_prev_ff && !trip_ff && !dropoff_seen_ff;
   assign prog_num     = 39'(step_index_ff) * 39'd100;
   assign ratio_ok     = (pickup_seen_ff || rise) && (dropoff_seen_ff || fall) &&
                         ((rise ? level_ff : pickup_level_ff) != '0);

   always_comb begin
      if (ramp_up_ff && next_sum > $signed({run_end_ff[VALUE_W-1], run_end_ff}))
         next_level = run_end_ff;
      else if (!ramp_up_ff && next_sum < $signed({run_end_ff[VALUE_W-1], run_end_ff}))
         next_level = run_end_ff;
      else
         next_level = next_sum[VALUE_W-1:0];
   end

   // ratio operands take the capture registers, or the current level where this tick captures it
   logic [DIVS_W-1:0] pick_mag, drop_mag;
   logic signed [VALUE_W-1:0] pick_lv, drop_lv;
   assign pick_lv  = rise ? level_ff : pickup_level_ff;
   assign drop_lv  = fall ? level_ff : dropoff_level_ff;
   assign pick_mag = pick_lv[VALUE_W-1] ? DIVS_W'(-pick_lv) : DIVS_W'(pick_lv);
   assign drop_mag = drop_lv[VALUE_W-1] ? DIVS_W'(-drop_lv) : DIVS_W'(drop_lv);

   logic is_last_step;
   assign is_last_step = op_ff == OP_TICK && run_active_ff && hold_end &&
                         !(step_index_ff < step_total_ff);

   // sequencer next state and divider launch
   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      req_tready   = state_ff == S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (step_total_ff == '0) begin
                  state_in = S_EXEC;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = DIVD_W'(prog_num);
                  div_divisor  = step_total_ff;
                  state_in     = S_PROG_WAIT;
               end
            end
         end
         S_PROG_WAIT: if (div_done) state_in = S_EXEC;
         S_EXEC: begin
            state_in = S_OUT;
            if (op_ff == OP_START && !run_active_ff && cfg_step_ff != '0 && !bad_dir &&
                range_mag != '0) begin
               div_start    = 1'b1;
               div_dividend = DIVD_W'(range_mag);
               div_divisor  = step_mag;
               state_in     = S_START_WAIT;
            end else if (is_last_step && ratio_ok) begin
               div_start    = 1'b1;
               div_dividend = {drop_mag, {FRAC_W{1'b0}}};
               div_divisor  = pick_mag;
               state_in     = S_RATIO_WAIT;
            end
         end
         S_START_WAIT: if (div_done) state_in = S_OUT;
         S_RATIO_WAIT: if (div_done) state_in = S_OUT;
         S_OUT:        if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // datapath updates per sequencer step
   always_ff @(posedge clock) begin
      if (reset) begin
         run_active_ff    <= 1'b0;
         trip_prev_ff     <= 1'b0;
         ramp_up_ff       <= 1'b0;
         pickup_seen_ff   <= 1'b0;
         dropoff_seen_ff  <= 1'b0;
         level_ff         <= '0;
         pickup_level_ff  <= '0;
         dropoff_level_ff <= '0;
         ratio_ff         <= '0;
         run_end_ff       <= '0;
         run_step_ff      <= '0;
         run_ticks_ff     <= '0;
         run_monitor_ff   <= 1'b0;
         step_index_ff    <= '0;
         step_total_ff    <= '0;
         hold_ff          <= '0;
         elapsed_ff       <= '0;
         pickup_at_ff     <= '0;
         dropoff_at_ff    <= '0;
         last_status_ff   <= ST_CODE_IDLE;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff      <= req_tuser;
                  trip_ff    <= req_tdata[0];
                  shown_ff   <= level_ff;
                  prog_ff    <= '0;
                  sampled_ff <= 1'b0;
                  done_ff    <= 1'b0;
               end
            end
            S_PROG_WAIT: if (div_done) prog_ff <= div_quot[6:0];
            S_EXEC: begin
               if (op_ff == OP_START) begin
                  // any start while idle reports zero progress
                  if (!run_active_ff) prog_ff <= '0;
                  if (run_active_ff) begin
                     status_ff <= ST_CODE_BUSY;
                  end else if (cfg_step_ff == '0) begin
                     status_ff      <= ST_CODE_ZERO;
                     last_status_ff <= ST_CODE_ZERO;
                  end else if (bad_dir) begin
                     status_ff      <= ST_CODE_WRONG;
                     last_status_ff <= ST_CODE_WRONG;
                  end else if (range_mag == '0) begin
                     status_ff      <= ST_CODE_NOSTEP;
                     last_status_ff <= ST_CODE_NOSTEP;
                  end else begin
                     status_ff <= last_status_ff;
                  end
               end else if (op_ff == OP_STOP && run_active_ff) begin
                  run_active_ff  <= 1'b0;
                  last_status_ff <= ST_CODE_STOPPED;
                  status_ff      <= ST_CODE_STOPPED;
               end else if (op_ff == OP_TICK && run_active_ff) begin
                  elapsed_ff <= elapsed_next;
                  if (hold_end) begin
                     done_ff <= 1'b1;
                     if (run_monitor_ff) begin
                        sampled_ff   <= trip_ff;
                        trip_prev_ff <= trip_ff;
                     end
                     if (rise) begin
                        pickup_seen_ff  <= 1'b1;
                        pickup_level_ff <= level_ff;
                        pickup_at_ff    <= elapsed_next;
                     end
                     if (fall) begin
                        dropoff_seen_ff  <= 1'b1;
                        dropoff_level_ff <= level_ff;
                        dropoff_at_ff    <= elapsed_next;
                     end
                     if (step_index_ff < step_total_ff) begin
                        level_ff      <= next_level;
                        step_index_ff <= step_index_ff + 32'd1;
                        hold_ff       <= '0;
                        status_ff     <= last_status_ff;
                     end else begin
                        hold_ff        <= hold_next[31:0];
                        run_active_ff  <= 1'b0;
                        last_status_ff <= ST_CODE_DONE;
                        status_ff      <= ST_CODE_DONE;
                        ratio_neg_ff   <= pick_lv[VALUE_W-1] ^ drop_lv[VALUE_W-1];
                     end
                  end else begin
                     hold_ff   <= hold_next[31:0];
                     status_ff <= last_status_ff;
                  end
               end else begin
                  status_ff <= last_status_ff;
               end
            end
            S_START_WAIT: begin
               if (div_done) begin
                  run_active_ff    <= 1'b1;
                  ramp_up_ff       <= dir_up;
                  level_ff         <= cfg_start_ff;
                  shown_ff         <= cfg_start_ff;
                  run_end_ff       <= cfg_end_ff;
                  run_step_ff      <= cfg_step_ff;
                  run_ticks_ff     <= (cfg_ticks_ff == '0) ? 32'd1 : cfg_ticks_ff;
                  run_monitor_ff   <= cfg_monitor_ff;
                  step_index_ff    <= '0;
                  step_total_ff    <= div_quot[31:0] + {31'd0, div_rem != '0};
                  hold_ff          <= '0;
                  elapsed_ff       <= '0;
                  trip_prev_ff     <= cfg_monitor_ff & trip_ff;
                  pickup_seen_ff   <= 1'b0;
                  dropoff_seen_ff  <= 1'b0;
                  pickup_level_ff  <= '0;
                  dropoff_level_ff <= '0;
                  pickup_at_ff     <= '0;
                  dropoff_at_ff    <= '0;
                  ratio_ff         <= '0;
                  prog_ff          <= '0;
                  status_ff        <= ST_CODE_RUNNING;
                  last_status_ff   <= ST_CODE_RUNNING;
               end
            end
            S_RATIO_WAIT: begin
               // saturate the signed quotient
               if (div_done) begin
                  if (ratio_neg_ff) begin
                     if (div_quot > DIVD_W'(33'h080000000))
                        ratio_ff <= {1'b1, {(VALUE_W-1){1'b0}}};
                     else
                        ratio_ff <= VALUE_W'(-div_quot);
                  end else begin
                     if (div_quot > DIVD_W'(32'h7FFFFFFF))
                        ratio_ff <= {1'b0, {(VALUE_W-1){1'b1}}};
                     else
                        ratio_ff <= div_quot[VALUE_W-1:0];
                  end
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {elapsed_ff, ratio_ff, dropoff_at_ff, pickup_at_ff,
                                   dropoff_level_ff, pickup_level_ff, status_ff, done_ff,
                                   sampled_ff, prog_ff, cfg_quantity_ff, shown_ff};
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire
